// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/bcr_pkg.sv =====
// Types, constants and helpers of the box collision resolver.
`timescale 1ns / 1ps
package bcr_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int RAD_W         = 20;
    localparam int D2_W          = 2 * RAD_W;
    localparam int VAL_W         = 24;

    // round(v / 5) by reciprocal: (a + 2) * K >> SH
    localparam logic [23:0] FIFTH_K  = 24'd13421773;
    localparam int          FIFTH_SH = 26;

    localparam logic [1:0] CFG_BOX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_BOX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_OFFSET_X   = 2'd2;
    localparam logic [1:0] CFG_OFFSET_Y   = 2'd3;

    localparam logic [3:0] SIDE_LEFT   = 4'b0001;
    localparam logic [3:0] SIDE_RIGHT  = 4'b0010;
    localparam logic [3:0] SIDE_TOP    = 4'b0100;
    localparam logic [3:0] SIDE_BOTTOM = 4'b1000;

    typedef struct packed {
        logic               kind;
        logic signed [23:0] self_x;
        logic signed [23:0] self_y;
        logic signed [23:0] other_x;
        logic signed [23:0] other_y;
        logic [11:0]        other_width;
        logic [11:0]        other_height;
        logic [19:0]        other_radius;
        logic signed [23:0] self_vel_x;
        logic signed [23:0] self_vel_y;
        logic signed [23:0] other_vel_y;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic [3:0]         side_bits;
        logic signed [23:0] push_x;
        logic signed [23:0] push_y;
        logic signed [23:0] new_self_vel_x;
        logic signed [23:0] new_self_vel_y;
        logic signed [23:0] new_other_vel_y;
    } t_out;

    typedef struct packed {
        logic             circ;
        t_out             res;
        logic [RAD_W-1:0] adx;
        logic [RAD_W-1:0] ady;
        logic [RAD_W-1:0] rad;
    } t_ctx;

    function automatic logic [VAL_W-1:0] sat_signed(input logic [31:0] mag, input logic neg);
        logic [VAL_W-1:0] res;
        if (neg) begin
            res = (mag > 32'h0080_0000) ? 24'h80_0000 : (~mag[VAL_W-1:0] + 24'd1);
        end else begin
            res = (mag > 32'h007F_FFFF) ? 24'h7F_FFFF : mag[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/box_collision_resolver.sv =====
// Top level of the box collision resolver.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Tests this box against another box (kind 0) or a circle (kind 1) and returns one result
// transaction per input transaction, in order. The block is a 46-stage pipeline: four front
// stages (centers, box test, clamp, squares), 20 square-root stages, one multiply stage and
// 20 divide stages for the circle push, and the output register. A transaction may enter
// every cycle while the output is not stalled. A stalled output freezes the whole pipeline,
// so input ready follows output ready while a result waits. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the block is idle, as
// the block does not enforce this. The registers reset to zero.
module box_collision_resolver #(
    parameter int FRAC_BITS = bcr_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bcr_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bcr_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [23:0]    i_cfg_data
);
    import bcr_pkg::*;

    logic        w_en;
    logic [11:0] r_box_width, r_box_height;
    logic [23:0] r_offset_x, r_offset_y;

    logic             w_f_vld, w_s_vld, w_d_vld;
    t_ctx             w_f_ctx, w_s_ctx, w_d_ctx;
    logic [D2_W-1:0]  w_f_d2;
    logic [RAD_W-1:0] w_s_len, w_tx, w_ty;
    logic [RAD_W:0]   w_mx, w_my;
    logic [23:0]      w_mxe, w_mye;
    t_out             w_res;
    logic             r_out_vld;
    t_out             r_out;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= '0;
            r_box_height <= '0;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data[11:0];
                CFG_BOX_HEIGHT: r_box_height <= i_cfg_data[11:0];
                CFG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                CFG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bcr_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (i_in_valid),
        .i_data       (i_in_data),
        .i_box_width  (r_box_width),
        .i_box_height (r_box_height),
        .i_offset_x   (r_offset_x),
        .i_offset_y   (r_offset_y),
        .o_vld        (w_f_vld),
        .o_ctx        (w_f_ctx),
        .o_d2         (w_f_d2)
    );

    bcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_ctx   (w_f_ctx),
        .i_d2    (w_f_d2),
        .o_vld   (w_s_vld),
        .o_ctx   (w_s_ctx),
        .o_len   (w_s_len)
    );

    bcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_ctx   (w_s_ctx),
        .i_len   (w_s_len),
        .o_vld   (w_d_vld),
        .o_ctx   (w_d_ctx),
        .o_tx    (w_tx),
        .o_ty    (w_ty)
    );

    // circle push magnitude t - |d|, signed by side
    assign w_mx  = {1'b0, w_tx} - {1'b0, w_d_ctx.adx};
    assign w_my  = {1'b0, w_ty} - {1'b0, w_d_ctx.ady};
    assign w_mxe = {{(24-RAD_W-1){w_mx[RAD_W]}}, w_mx};
    assign w_mye = {{(24-RAD_W-1){w_my[RAD_W]}}, w_my};

    always_comb begin
        w_res = w_d_ctx.res;
        if (w_d_ctx.circ && w_d_ctx.res.hit) begin
            w_res.push_x = w_d_ctx.res.side_bits[0] ? (~w_mxe + 24'd1) : w_mxe;
            w_res.push_y = w_d_ctx.res.side_bits[2] ? (~w_mye + 24'd1) : w_mye;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `ASSERT_IMPLIES(a_nohit_clear, i_clk, i_rst_n, o_out_valid && !o_out_data.hit, (o_out_data.side_bits == 4'd0) && (o_out_data.push_x == 24'd0) && (o_out_data.push_y == 24'd0), "no-hit result carries side bits or push")
    `ASSERT_IMPLIES(a_hit_sides, i_clk, i_rst_n, o_out_valid && o_out_data.hit, ($countones(o_out_data.side_bits) == 1) || ($countones(o_out_data.side_bits) == 2), "hit result has bad side bits")
    `ASSERT_IMPLIES(a_stall_ready, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready, "input taken while output stalled")
    `ASSERT_NEXT(a_adv_out, i_clk, i_rst_n, w_en && w_d_vld, o_out_valid, "pipeline result dropped at output")

endmodule

// ===== hdl/bcr_front.sv =====
// Front stages: box centers, box test and response, circle clamp and distance.
`timescale 1ns / 1ps
module bcr_front #(
    parameter int FRAC_BITS = bcr_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  bcr_pkg::t_in                      i_data,
    input  logic [11:0]                       i_box_width,
    input  logic [11:0]                       i_box_height,
    input  logic [23:0]                       i_offset_x,
    input  logic [23:0]                       i_offset_y,
    output logic                              o_vld,
    output bcr_pkg::t_ctx                     o_ctx,
    output logic [bcr_pkg::D2_W-1:0]          o_d2
);
    import bcr_pkg::*;

    localparam int HW_W = 12 + FRAC_BITS;
    localparam int MX_W = (HW_W > VAL_W) ? HW_W : VAL_W;
    localparam int CW   = MX_W + 3;
    localparam int PW   = 48;

    // stage a
    logic [HW_W:0]   w_ws, w_hs, w_ows, w_ohs;
    logic [HW_W-1:0] w_hw, w_hh;
    logic [CW-1:0]   w_cx, w_cy;
    logic            r_a_vld;
    t_in             r_a_in;
    logic [CW-1:0]   r_a_cx, r_a_cy;
    logic [HW_W-1:0] r_a_hw, r_a_hh, r_a_sumx, r_a_sumy;

    assign w_ws  = (HW_W + 1)'(i_box_width) << FRAC_BITS;
    assign w_hs  = (HW_W + 1)'(i_box_height) << FRAC_BITS;
    assign w_ows = (HW_W + 1)'(i_data.other_width) << FRAC_BITS;
    assign w_ohs = (HW_W + 1)'(i_data.other_height) << FRAC_BITS;
    assign w_hw  = w_ws[HW_W:1];
    assign w_hh  = w_hs[HW_W:1];
    assign w_cx  = {{(CW-VAL_W){i_data.self_x[23]}}, i_data.self_x}
                 + {{(CW-HW_W){1'b0}}, w_hw}
                 + {{(CW-VAL_W){i_offset_x[23]}}, i_offset_x};
    assign w_cy  = {{(CW-VAL_W){i_data.self_y[23]}}, i_data.self_y}
                 + {{(CW-HW_W){1'b0}}, w_hh}
                 + {{(CW-VAL_W){i_offset_y[23]}}, i_offset_y};

    // stage b
    logic [CW-1:0] w_ox, w_oy, w_hwe, w_hhe, w_difx, w_dify;
    logic [CW-1:0] w_lox, w_hix, w_loy, w_hiy, w_clx, w_cly;
    logic          r_b_vld;
    t_in           r_b_in;
    logic [CW-1:0] r_b_adx, r_b_ady, r_b_dx, r_b_dy;
    logic [HW_W-1:0] r_b_sumx, r_b_sumy;
    logic          r_b_ltx, r_b_lty;

    assign w_ox   = {{(CW-VAL_W){r_a_in.other_x[23]}}, r_a_in.other_x};
    assign w_oy   = {{(CW-VAL_W){r_a_in.other_y[23]}}, r_a_in.other_y};
    assign w_hwe  = {{(CW-HW_W){1'b0}}, r_a_hw};
    assign w_hhe  = {{(CW-HW_W){1'b0}}, r_a_hh};
    assign w_difx = w_ox - r_a_cx;
    assign w_dify = w_oy - r_a_cy;
    assign w_lox  = r_a_cx - w_hwe;
    assign w_hix  = r_a_cx + w_hwe;
    assign w_loy  = r_a_cy - w_hhe;
    assign w_hiy  = r_a_cy + w_hhe;
    assign w_clx  = ($signed(w_ox) > $signed(w_hix)) ? w_hix :
                    (($signed(w_ox) < $signed(w_lox)) ? w_lox : w_ox);
    assign w_cly  = ($signed(w_oy) > $signed(w_hiy)) ? w_hiy :
                    (($signed(w_oy) < $signed(w_loy)) ? w_loy : w_oy);

    // stage c
    logic [CW-1:0]      w_acx, w_acy;
    logic signed [23:0] w_vsel;
    logic [23:0]        w_av;
    logic               r_c_vld;
    t_in                r_c_in;
    logic               r_c_ltx, r_c_lty, r_c_bhit, r_c_horiz, r_c_vpos, r_c_big;
    logic [HW_W-1:0]    r_c_penx, r_c_peny;
    logic [PW-1:0]      r_c_prod;
    logic [RAD_W-1:0]   r_c_adx, r_c_ady;
    logic [D2_W-1:0]    r_c_sqx, r_c_sqy, r_c_rr;
    logic [HW_W-1:0]    w_penx, w_peny;

    assign w_acx  = r_b_dx[CW-1] ? (~r_b_dx + CW'(1)) : r_b_dx;
    assign w_acy  = r_b_dy[CW-1] ? (~r_b_dy + CW'(1)) : r_b_dy;
    assign w_vsel = r_b_lty ? r_b_in.other_vel_y : r_b_in.self_vel_y;
    assign w_av   = w_vsel[23] ? (~w_vsel + 24'd1) : w_vsel;
    assign w_penx = r_b_sumx - r_b_adx[HW_W-1:0];
    assign w_peny = r_b_sumy - r_b_ady[HW_W-1:0];

    // stage d
    logic [D2_W:0]      w_d2;
    logic               w_chit;
    logic [23:0]        w_q, w_fifth, w_ppx, w_ppy;
    t_ctx               w_ctx;
    logic               r_d_vld;
    t_ctx               r_d_ctx;
    logic [D2_W-1:0]    r_d_d2;

    assign w_d2    = {1'b0, r_c_sqx} + {1'b0, r_c_sqy};
    assign w_chit  = !r_c_big && (w_d2 < {1'b0, r_c_rr});
    assign w_q     = 24'(r_c_prod >> FIFTH_SH);
    assign w_fifth = r_c_vpos ? (~w_q + 24'd1) : w_q;
    assign w_ppx   = sat_signed(32'(r_c_penx), r_c_ltx);
    assign w_ppy   = sat_signed(32'(r_c_peny), r_c_lty);

    always_comb begin
        w_ctx                     = '0;
        w_ctx.circ                = r_c_in.kind;
        w_ctx.adx                 = r_c_adx;
        w_ctx.ady                 = r_c_ady;
        w_ctx.rad                 = r_c_in.other_radius;
        w_ctx.res.new_self_vel_x  = r_c_in.self_vel_x;
        w_ctx.res.new_self_vel_y  = r_c_in.self_vel_y;
        w_ctx.res.new_other_vel_y = r_c_in.other_vel_y;
        if (r_c_in.kind) begin
            w_ctx.res.hit = w_chit;
            if (w_chit) begin
                w_ctx.res.side_bits = (r_c_ltx ? SIDE_LEFT : SIDE_RIGHT)
                                    | (r_c_lty ? SIDE_TOP : SIDE_BOTTOM);
            end
        end else if (r_c_bhit) begin
            w_ctx.res.hit = 1'b1;
            if (r_c_horiz) begin
                w_ctx.res.side_bits      = r_c_ltx ? SIDE_LEFT : SIDE_RIGHT;
                w_ctx.res.push_x         = w_ppx;
                w_ctx.res.new_self_vel_x = '0;
            end else if (r_c_lty) begin
                w_ctx.res.side_bits       = SIDE_TOP;
                w_ctx.res.push_y          = w_ppy;
                w_ctx.res.new_self_vel_y  = '0;
                w_ctx.res.new_other_vel_y = w_fifth;
            end else begin
                w_ctx.res.side_bits       = SIDE_BOTTOM;
                w_ctx.res.push_y          = w_ppy;
                w_ctx.res.new_self_vel_y  = w_fifth;
                w_ctx.res.new_other_vel_y = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_in   <= i_data;
            r_a_cx   <= w_cx;
            r_a_cy   <= w_cy;
            r_a_hw   <= w_hw;
            r_a_hh   <= w_hh;
            r_a_sumx <= w_hw + w_ows[HW_W:1];
            r_a_sumy <= w_hh + w_ohs[HW_W:1];

            r_b_in   <= r_a_in;
            r_b_adx  <= w_difx[CW-1] ? (~w_difx + CW'(1)) : w_difx;
            r_b_ady  <= w_dify[CW-1] ? (~w_dify + CW'(1)) : w_dify;
            r_b_dx   <= w_ox - w_clx;
            r_b_dy   <= w_oy - w_cly;
            r_b_sumx <= r_a_sumx;
            r_b_sumy <= r_a_sumy;
            r_b_ltx  <= $signed(r_a_cx) < $signed(w_ox);
            r_b_lty  <= $signed(r_a_cy) < $signed(w_oy);

            r_c_in    <= r_b_in;
            r_c_ltx   <= r_b_ltx;
            r_c_lty   <= r_b_lty;
            r_c_bhit  <= (r_b_adx <= CW'(r_b_sumx)) && (r_b_ady <= CW'(r_b_sumy));
            r_c_horiz <= w_penx < w_peny;
            r_c_penx  <= w_penx;
            r_c_peny  <= w_peny;
            r_c_vpos  <= !w_vsel[23];
            r_c_prod  <= (w_av + 24'd2) * FIFTH_K;
            r_c_big   <= (|w_acx[CW-1:RAD_W]) || (|w_acy[CW-1:RAD_W]);
            r_c_adx   <= w_acx[RAD_W-1:0];
            r_c_ady   <= w_acy[RAD_W-1:0];
            r_c_sqx   <= w_acx[RAD_W-1:0] * w_acx[RAD_W-1:0];
            r_c_sqy   <= w_acy[RAD_W-1:0] * w_acy[RAD_W-1:0];
            r_c_rr    <= r_b_in.other_radius * r_b_in.other_radius;

            r_d_ctx <= w_ctx;
            r_d_d2  <= w_d2[D2_W-1:0];
        end
    end

    assign o_vld = r_d_vld;
    assign o_ctx = r_d_ctx;
    assign o_d2  = r_d_d2;

endmodule

// ===== hdl/bcr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module bcr_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  bcr_pkg::t_ctx              i_ctx,
    input  logic [bcr_pkg::D2_W-1:0]   i_d2,
    output logic                       o_vld,
    output bcr_pkg::t_ctx              o_ctx,
    output logic [bcr_pkg::RAD_W-1:0]  o_len
);
    import bcr_pkg::*;

    localparam int N = RAD_W;

    logic             w_vld [0:N-1];
    t_ctx             w_ctx [0:N-1];
    logic [D2_W-1:0]  w_rem [0:N-1];
    logic [N-1:0]     w_q   [0:N-1];
    logic             r_vld [0:N-1];
    t_ctx             r_ctx [0:N-1];
    logic [D2_W-1:0]  r_rem [0:N-1];
    logic [N-1:0]     r_q   [0:N-1];

    assign w_vld[0] = i_vld;
    assign w_ctx[0] = i_ctx;
    assign w_rem[0] = i_d2;
    assign w_q[0]   = '0;

    for (genvar s = 0; s < N; s++) begin : g_st
        localparam int B = N - 1 - s;
        logic [D2_W+1:0] w_trial;
        logic            w_take;

        if (s > 0) begin : g_link
            assign w_vld[s] = r_vld[s-1];
            assign w_ctx[s] = r_ctx[s-1];
            assign w_rem[s] = r_rem[s-1];
            assign w_q[s]   = r_q[s-1];
        end

        assign w_trial = ((D2_W + 2)'(w_q[s]) << (B + 1)) + ((D2_W + 2)'(1) << (2 * B));
        assign w_take  = {2'b00, w_rem[s]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[s] <= w_ctx[s];
                r_rem[s] <= w_take ? (w_rem[s] - w_trial[D2_W-1:0]) : w_rem[s];
                r_q[s]   <= w_take ? (w_q[s] | (N'(1) << B)) : w_q[s];
            end
        end
    end

    assign o_vld = r_vld[N-1];
    assign o_ctx = r_ctx[N-1];
    assign o_len = r_q[N-1];

endmodule

// ===== hdl/bcr_div.sv =====
// Scales both circle axes by radius and divides by length, one quotient bit per stage.
`timescale 1ns / 1ps
module bcr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  bcr_pkg::t_ctx              i_ctx,
    input  logic [bcr_pkg::RAD_W-1:0]  i_len,
    output logic                       o_vld,
    output bcr_pkg::t_ctx              o_ctx,
    output logic [bcr_pkg::RAD_W-1:0]  o_tx,
    output logic [bcr_pkg::RAD_W-1:0]  o_ty
);
    import bcr_pkg::*;

    localparam int N = RAD_W;

    logic             r_m_vld;
    t_ctx             r_m_ctx;
    logic [N-1:0]     r_m_den;
    logic [D2_W-1:0]  r_m_nx, r_m_ny;

    logic             w_vld [0:N-1];
    t_ctx             w_ctx [0:N-1];
    logic [N-1:0]     w_den [0:N-1];
    logic [D2_W-1:0]  w_rx  [0:N-1];
    logic [D2_W-1:0]  w_ry  [0:N-1];
    logic [N-1:0]     w_qx  [0:N-1];
    logic [N-1:0]     w_qy  [0:N-1];
    logic             r_vld [0:N-1];
    t_ctx             r_ctx [0:N-1];
    logic [N-1:0]     r_den [0:N-1];
    logic [D2_W-1:0]  r_rx  [0:N-1];
    logic [D2_W-1:0]  r_ry  [0:N-1];
    logic [N-1:0]     r_qx  [0:N-1];
    logic [N-1:0]     r_qy  [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (i_en) begin
            r_m_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_ctx <= i_ctx;
            r_m_den <= i_len;
            r_m_nx  <= i_ctx.adx * i_ctx.rad;
            r_m_ny  <= i_ctx.ady * i_ctx.rad;
        end
    end

    assign w_vld[0] = r_m_vld;
    assign w_ctx[0] = r_m_ctx;
    assign w_den[0] = r_m_den;
    assign w_rx[0]  = r_m_nx;
    assign w_ry[0]  = r_m_ny;
    assign w_qx[0]  = '0;
    assign w_qy[0]  = '0;

    for (genvar s = 0; s < N; s++) begin : g_st
        localparam int B = N - 1 - s;
        logic [D2_W:0] w_sub;
        logic          w_tx, w_ty;

        if (s > 0) begin : g_link
            assign w_vld[s] = r_vld[s-1];
            assign w_ctx[s] = r_ctx[s-1];
            assign w_den[s] = r_den[s-1];
            assign w_rx[s]  = r_rx[s-1];
            assign w_ry[s]  = r_ry[s-1];
            assign w_qx[s]  = r_qx[s-1];
            assign w_qy[s]  = r_qy[s-1];
        end

        assign w_sub = (D2_W + 1)'(w_den[s]) << B;
        assign w_tx  = {1'b0, w_rx[s]} >= w_sub;
        assign w_ty  = {1'b0, w_ry[s]} >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[s] <= w_ctx[s];
                r_den[s] <= w_den[s];
                r_rx[s]  <= w_tx ? (w_rx[s] - w_sub[D2_W-1:0]) : w_rx[s];
                r_ry[s]  <= w_ty ? (w_ry[s] - w_sub[D2_W-1:0]) : w_ry[s];
                r_qx[s]  <= w_tx ? (w_qx[s] | (N'(1) << B)) : w_qx[s];
                r_qy[s]  <= w_ty ? (w_qy[s] | (N'(1) << B)) : w_qy[s];
            end
        end
    end

    // zero length: zero direction
    assign o_vld = r_vld[N-1];
    assign o_ctx = r_ctx[N-1];
    assign o_tx  = (r_den[N-1] == '0) ? '0 : r_qx[N-1];
    assign o_ty  = (r_den[N-1] == '0) ? '0 : r_qy[N-1];

endmodule

// ===== sim/box_collision_resolver_tb.sv =====
// Testbench for box_collision_resolver: directed and random collision checks against a predictor.
`timescale 1ns / 1ps
module box_collision_resolver_tb;
    import bcr_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int IN_W         = $bits(t_in);

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    t_in           i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    t_out          o_out_data;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [23:0]   i_cfg_data;

    logic [11:0]        box_w;
    logic [11:0]        box_h;
    logic signed [23:0] off_x;
    logic signed [23:0] off_y;

    t_out contact_q[$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;

    box_collision_resolver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("box_collision_resolver verification failed");
        $finish;
    end

    function automatic logic signed [23:0] sat24(longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic longint half_size(logic [11:0] s);
        return (longint'(s) << 8) >>> 1;
    endfunction

    function automatic longint neg_fifth(longint v);
        longint n;
        n = -v;
        if (n >= 0) return (n + 2) / 5;
        return -((-n + 2) / 5);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic t_out predict_contact(t_in it);
        t_out r;
        longint hw, hh, cx, cy, ox, oy, vx, vy, ovy, px, py;
        longint sumx, sumy, adx, ady, penx, peny, rad, dx, dy, len, tx, ty;
        longint unsigned d2;
        logic [3:0] sides;
        logic hit;
        hw = half_size(box_w);
        hh = half_size(box_h);
        cx = longint'(it.self_x) + hw + longint'(off_x);
        cy = longint'(it.self_y) + hh + longint'(off_y);
        ox = longint'(it.other_x);
        oy = longint'(it.other_y);
        vx = longint'(it.self_vel_x);
        vy = longint'(it.self_vel_y);
        ovy = longint'(it.other_vel_y);
        hit = 1'b0;
        sides = '0;
        px = 0;
        py = 0;
        if (it.kind == 1'b0) begin
            sumx = hw + half_size(it.other_width);
            sumy = hh + half_size(it.other_height);
            adx = (ox - cx < 0) ? cx - ox : ox - cx;
            ady = (oy - cy < 0) ? cy - oy : oy - cy;
            if (adx <= sumx && ady <= sumy) begin
                penx = sumx - adx;
                peny = sumy - ady;
                hit = 1'b1;
                if (penx < peny) begin
                    if (cx < ox) begin
                        sides = SIDE_LEFT;
                        px = -penx;
                    end else begin
                        sides = SIDE_RIGHT;
                        px = penx;
                    end
                    vx = 0;
                end else if (cy < oy) begin
                    sides = SIDE_TOP;
                    py = -peny;
                    vy = 0;
                    ovy = neg_fifth(ovy);
                end else begin
                    sides = SIDE_BOTTOM;
                    py = peny;
                    ovy = 0;
                    vy = neg_fifth(vy);
                end
            end
        end else begin
            rad = longint'(it.other_radius);
            dx = ox - clampl(ox, cx - hw, cx + hw);
            dy = oy - clampl(oy, cy - hh, cy + hh);
            d2 = longint'(dx * dx) + longint'(dy * dy);
            if (d2 < longint'(rad * rad)) begin
                adx = (dx < 0) ? -dx : dx;
                ady = (dy < 0) ? -dy : dy;
                len = int_sqrt(d2);
                tx = 0;
                ty = 0;
                hit = 1'b1;
                if (len != 0) begin
                    tx = (adx * rad) / len;
                    ty = (ady * rad) / len;
                end
                if (cx < ox) begin
                    sides |= SIDE_LEFT;
                    px = -(tx - adx);
                end else begin
                    sides |= SIDE_RIGHT;
                    px = tx - adx;
                end
                if (cy < oy) begin
                    sides |= SIDE_TOP;
                    py = -(ty - ady);
                end else begin
                    sides |= SIDE_BOTTOM;
                    py = ty - ady;
                end
            end
        end
        r.hit = hit;
        r.side_bits = sides;
        r.push_x = sat24(px);
        r.push_y = sat24(py);
        r.new_self_vel_x = sat24(vx);
        r.new_self_vel_y = sat24(vy);
        r.new_other_vel_y = sat24(ovy);
        return r;
    endfunction

    // receiver: random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    // outputs are stable by the falling edge; valid && ready here means taken at next rise
    always @(negedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (contact_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction %h", $time, o_out_data);
            end else begin
                exp_r = contact_q.pop_front();
                check_field("hit", exp_r.hit, o_out_data.hit);
                check_field("side_bits", exp_r.side_bits, o_out_data.side_bits);
                check_field("push_x", exp_r.push_x, o_out_data.push_x);
                check_field("push_y", exp_r.push_y, o_out_data.push_y);
                check_field("new_self_vel_x", exp_r.new_self_vel_x, o_out_data.new_self_vel_x);
                check_field("new_self_vel_y", exp_r.new_self_vel_y, o_out_data.new_self_vel_y);
                check_field("new_other_vel_y", exp_r.new_other_vel_y,
                            o_out_data.new_other_vel_y);
            end
        end
    end

    task automatic send_pair(t_in it);
        bit took;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        contact_q.push_back(predict_contact(it));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_BOX_WIDTH:  box_w = val[11:0];
            CFG_BOX_HEIGHT: box_h = val[11:0];
            CFG_OFFSET_X:   off_x = val;
            default:        off_y = val;
        endcase
    endtask

    task automatic set_box(logic [11:0] w, logic [11:0] h, logic [23:0] ox, logic [23:0] oy);
        wait_idle();
        write_reg(CFG_BOX_WIDTH, {12'd0, w});
        write_reg(CFG_BOX_HEIGHT, {12'd0, h});
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in make_pair(int k, int sx, int sy, int ox, int oy, int ow, int oh,
                                      int r, int vx, int vy, int ovy);
        t_in it;
        it.kind = k[0];
        it.self_x = sx[23:0];
        it.self_y = sy[23:0];
        it.other_x = ox[23:0];
        it.other_y = oy[23:0];
        it.other_width = ow[11:0];
        it.other_height = oh[11:0];
        it.other_radius = r[19:0];
        it.self_vel_x = vx[23:0];
        it.self_vel_y = vy[23:0];
        it.other_vel_y = ovy[23:0];
        return it;
    endfunction

    // random pair, mostly placed near this box so hits and misses both occur
    function automatic t_in random_pair();
        t_in it;
        longint cx, cy, span_x, span_y;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom});
        if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 3) != 0) begin
                it.other_width = 12'($urandom_range(0, 64));
                it.other_height = 12'($urandom_range(0, 64));
            end
            if ($urandom_range(0, 3) != 0) it.other_radius = 20'($urandom_range(0, 20000));
            cx = longint'(it.self_x) + half_size(box_w) + longint'(off_x);
            cy = longint'(it.self_y) + half_size(box_h) + longint'(off_y);
            span_x = half_size(box_w) + half_size(it.other_width) + it.other_radius + 64;
            span_y = half_size(box_h) + half_size(it.other_height) + it.other_radius + 64;
            cx += longint'($urandom_range(0, 32'(2 * span_x))) - span_x;
            cy += longint'($urandom_range(0, 32'(2 * span_y))) - span_y;
            it.other_x = cx[23:0];
            it.other_y = cy[23:0];
        end
        return it;
    endfunction

    task automatic test_box_sides();
        set_box(12'd16, 12'd8, 24'd0, 24'd0);
        // this center (2048,1024), half sizes 2048 x 1024
        send_pair(make_pair(0, 0, 0, 4608 - 100, 1024, 4, 32, 0, 300, -300, 77));
        send_pair(make_pair(0, 0, 0, -512 + 100, 1024, 4, 32, 0, -300, 300, 77));
        send_pair(make_pair(0, 0, 0, 2048, 2304 - 50, 64, 2, 0, 300, 1000, -999));
        send_pair(make_pair(0, 0, 0, 2048, -256 + 50, 64, 2, 0, 300, -1001, 999));
        send_pair(make_pair(0, 0, 0, 4608, 1024, 4, 32, 0, 5, 6, 7));
        send_pair(make_pair(0, 0, 0, 4609, 1024, 4, 32, 0, 5, 6, 7));
        send_pair(make_pair(0, 0, 0, 4608 - 40, 2304 - 40, 4, 2, 0, 5, 6, 7));
        send_pair(make_pair(0, 0, 0, 2048, 1024, 0, 0, 0, -8388608, -8388608, -8388608));
    endtask

    task automatic test_circle_cases();
        send_pair(make_pair(1, 0, 0, 4096 + 300, 2048 + 400, 0, 0, 600, 11, 22, 33));
        send_pair(make_pair(1, 0, 0, -300, -400, 0, 0, 600, 11, 22, 33));
        send_pair(make_pair(1, 0, 0, 4096 + 300, 1024, 0, 0, 301, 1, 2, 3));
        send_pair(make_pair(1, 0, 0, 4096 + 300, 1024, 0, 0, 300, 1, 2, 3));
        send_pair(make_pair(1, 0, 0, 2048, 1024, 0, 0, 5, 1, 2, 3));
        send_pair(make_pair(1, 0, 0, 2048, 1024, 0, 0, 0, 1, 2, 3));
        send_pair(make_pair(1, 0, 0, 2048, -1000, 0, 0, 1048575, 8388607, -8388608, 0));
    endtask

    task automatic test_extremes();
        set_box(12'd4095, 12'd4095, 24'h7FFFFF, 24'h800000);
        send_pair(make_pair(0, 8388607, -8388608, -8388608, 8388607, 4095, 4095, 1048575,
                            8388607, -8388608, -8388608));
        send_pair(make_pair(0, -8388608, 8388607, 8388607, -8388608, 4095, 4095, 0,
                            -8388608, 8388607, 8388607));
        send_pair(make_pair(1, 8388607, 8388607, -8388608, -8388608, 0, 0, 1048575,
                            -1, -1, -1));
        send_pair(make_pair(0, 0, 0, 524160, -524160, 4095, 4095, 0, 3, -8388608, -8388608));
        set_box(12'd0, 12'd0, 24'd0, 24'd0);
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 9, 9, 9));
        send_pair(make_pair(1, 0, 0, 0, 0, 0, 0, 1, 9, 9, 9));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int s = 0; s < 3; s++) begin
            case ($urandom_range(0, 3))
                0: set_box(12'($urandom_range(0, 64)), 12'($urandom_range(0, 64)),
                           24'($urandom_range(0, 4000) - 2000),
                           24'($urandom_range(0, 4000) - 2000));
                1: set_box(12'($urandom), 12'($urandom), 24'($urandom), 24'($urandom));
                2: set_box(12'd4095, 12'd0, 24'h800000, 24'h7FFFFF);
                default: set_box(12'd0, 12'd4095, 24'd0, 24'($urandom));
            endcase
            for (int n = 0; n < count / 3; n++) send_pair(random_pair());
            if (s == 1) begin
                // hold off until the pipeline is empty, then resume
                i_in_valid <= 1'b0;
                while (contact_q.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        box_w = '0;
        box_h = '0;
        off_x = '0;
        off_y = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_BOX_WIDTH;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset value
        send_pair(make_pair(0, 0, 0, 100, 0, 2, 2, 0, 1, 2, 3));
        test_box_sides();
        test_circle_cases();
        test_extremes();
        test_random_phase(21, 67, 600);
        test_random_phase(67, 21, 600);
        test_random_phase(0, 0, 630);

        wait_idle();
        if (errors == 0) begin
            $display("box_collision_resolver verification clean");
        end else begin
            $display("box_collision_resolver verification failed");
        end
        $finish;
    end

endmodule
